@@ hw/rtl/sequence_reorder_window_defines.svh @@
// Assertion macros used by the checker file of the reorder window.
`ifndef SEQUENCE_REORDER_WINDOW_DEFINES_SVH
`define SEQUENCE_REORDER_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRW_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rs)) (a) |-> (c)) \
    else $error("srw check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRW_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rs)) (a) |=> (c)) \
    else $error("srw check failed");

`endif

@@ hw/rtl/srw_pkg.sv @@
// Package: sizes, codes and transaction types of the sequence reorder window.
`timescale 1ns / 1ps
`default_nettype none
package srw_pkg;
  // ring size must stay a power of two: slots are the low sequence bits
  localparam int RING_SIZE   = 16;
  localparam int SLOT_BITS   = $clog2(RING_SIZE);
  localparam int HANDLE_BITS = 16;
  localparam int SEQ_W       = 32;
  localparam int TIME_W      = 32;
  localparam int TO_W        = 16;
  localparam int KIND_W      = 2;
  localparam int OUT_CAP     = 16;
  localparam int CNT_W       = $clog2(OUT_CAP + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_REL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LATE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUP   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

  localparam logic REQ_DELIVER = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ = 1'b1;

  localparam logic [TO_W-1:0] TIMEOUT_RST = 16'd50;

  // decoded request passed from front to back
  typedef struct packed {
    logic                   is_tick;
    logic [SEQ_W-1:0]       seq;
    logic [HANDLE_BITS-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [HANDLE_BITS-1:0] handle;
    logic [SEQ_W-1:0]       seq;
    logic [SEQ_W-1:0]       skipped;
    logic                   last;
  } res_t;
endpackage
`default_nettype wire

@@ hw/rtl/srw_if.sv @@
// Channel interfaces: request input and result output.
`timescale 1ns / 1ps
`default_nettype none
interface srw_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [srw_pkg::SEQ_W-1:0]       seq;
  logic [srw_pkg::HANDLE_BITS-1:0] packet_handle;
  modport source (output valid, req_type, seq, packet_handle, input ready);
  modport sink   (input valid, req_type, seq, packet_handle, output ready);
endinterface

interface srw_out_if;
  logic                           valid;
  logic                           ready;
  logic [srw_pkg::KIND_W-1:0]      kind;
  logic [srw_pkg::HANDLE_BITS-1:0] handle_out;
  logic [srw_pkg::SEQ_W-1:0]       seq_out;
  logic [srw_pkg::SEQ_W-1:0]       skipped_before;
  logic                           last;
  modport source (output valid, kind, handle_out, seq_out, skipped_before, last,
                  input ready);
  modport sink   (input valid, kind, handle_out, seq_out, skipped_before, last,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/srw_front.sv @@
// Front end: registers incoming transactions and decodes the request type.
`timescale 1ns / 1ps
`default_nettype none
module srw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  srw_in_if.sink             in_ch,
  output srw_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  logic          v_r;
  srw_pkg::cmd_t cmd_r;

  assign in_ch.ready = !v_r || cmd_ready;
  assign cmd_valid   = v_r;
  assign cmd         = cmd_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  // payload, decoded
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r.is_tick <= (in_ch.req_type == srw_pkg::REQ_TICK);
      cmd_r.seq     <= in_ch.seq;
      cmd_r.handle  <= in_ch.packet_handle;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/srw_queue.sv @@
// Two-entry queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module srw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire srw_pkg::cmd_t wr_cmd,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output srw_pkg::cmd_t      rd_cmd,
  output logic               rd_valid,
  input  wire logic          rd_ready
);
  srw_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd   = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      if (wr && !rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_cmd;
  end
endmodule
`default_nettype wire

@@ hw/rtl/srw_back.sv @@
// Back end: ring storage, sequencer for deliver and tick, result register.
`timescale 1ns / 1ps
`default_nettype none
module srw_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire srw_pkg::cmd_t                    cmd,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire logic                             cfg_we,
  input  wire logic [srw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srw_pkg::CFG_DATA_W-1:0]   cfg_data,
  srw_out_if.source                             out_ch
);
  localparam int RS = srw_pkg::RING_SIZE;
  localparam int SB = srw_pkg::SLOT_BITS;
  localparam int SW = srw_pkg::SEQ_W;
  localparam int TW = srw_pkg::TIME_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TCHK  = 4'd1;
  localparam logic [3:0] ST_TLOOP = 4'd2;
  localparam logic [3:0] ST_DCLS  = 4'd3;
  localparam logic [3:0] ST_FLUSH = 4'd4;
  localparam logic [3:0] ST_STORE = 4'd5;
  localparam logic [3:0] ST_REL   = 4'd6;
  localparam logic [3:0] ST_END   = 4'd7;

  logic [3:0]                       state_r;
  logic [SW-1:0]                    exp_r, s_r, delta_r, skip_r;
  logic [RS-1:0]                    valid_r, aged_r;
  logic [srw_pkg::HANDLE_BITS-1:0]  handle_r [RS];
  logic [TW-1:0]                    arr_r [RS];
  logic [TW-1:0]                    time_r, dl_r;
  logic                             armed_r;
  logic [srw_pkg::TO_W-1:0]          timeout_r;
  logic [srw_pkg::HANDLE_BITS-1:0]  h_r;
  logic [SB-1:0]                    base_r, idx_r;
  logic [srw_pkg::CNT_W-1:0]         cnt_r;
  logic                             pend_v_r, out_v_r;
  srw_pkg::res_t                    pend_r, out_r;

  logic [SB-1:0]  exp_slot, s_slot, flush_off;
  logic [SW-1:0]  delta;
  logic [TW-1:0]  tdiff, time_to;
  logic [RS-1:0]  aged_nxt;
  logic           can_push, go, gen, emit, push;
  srw_pkg::res_t  gen_res, push_res;

  assign exp_slot  = exp_r[SB-1:0];
  assign s_slot    = s_r[SB-1:0];
  assign flush_off = idx_r - base_r;
  assign delta     = s_r - exp_r;
  assign tdiff     = time_r - dl_r;
  assign time_to   = time_r + TW'(timeout_r);
  assign can_push  = !out_v_r || out_ch.ready;
  assign go        = !pend_v_r || can_push;
  assign cmd_ready = (state_r == ST_IDLE);
  assign emit      = gen && (cnt_r != srw_pkg::CNT_W'(srw_pkg::OUT_CAP));
  assign push      = go && pend_v_r && (emit || state_r == ST_END);

  // per-slot age test, registered once per expiring tick
  always_comb begin
    logic [TW-1:0] d;
    for (int i = 0; i < RS; i++) begin
      d = time_r - (arr_r[i] + TW'(timeout_r));
      aged_nxt[i] = ~d[TW-1];
    end
  end

  // result produced by the current step
  always_comb begin
    gen             = 1'b0;
    gen_res.kind    = srw_pkg::KIND_REL;
    gen_res.handle  = h_r;
    gen_res.seq     = s_r;
    gen_res.skipped = '0;
    gen_res.last    = 1'b0;
    unique case (state_r)
      ST_DCLS: begin
        if (delta[SW-1]) begin
          gen          = 1'b1;
          gen_res.kind = srw_pkg::KIND_LATE;
        end
      end
      ST_FLUSH: begin
        if (valid_r[idx_r]) begin
          gen            = 1'b1;
          gen_res.kind   = srw_pkg::KIND_FLUSH;
          gen_res.handle = handle_r[idx_r];
          gen_res.seq    = exp_r + SW'(flush_off);
        end
      end
      ST_STORE: begin
        if (valid_r[s_slot]) begin
          gen          = 1'b1;
          gen_res.kind = srw_pkg::KIND_DUP;
        end
      end
      ST_TLOOP, ST_REL: begin
        if (valid_r[exp_slot]) begin
          gen             = 1'b1;
          gen_res.handle  = handle_r[exp_slot];
          gen_res.seq     = exp_r;
          gen_res.skipped = skip_r;
        end
      end
      default: ;
    endcase
  end

  // pending result with its last flag settled
  always_comb begin
    push_res      = pend_r;
    push_res.last = (state_r == ST_END);
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.handle_out     = out_r.handle;
  assign out_ch.seq_out        = out_r.seq;
  assign out_ch.skipped_before = out_r.skipped;
  assign out_ch.last           = out_r.last;

  // sequencer, result staging and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      exp_r     <= '0;
      valid_r   <= '0;
      time_r    <= '0;
      dl_r      <= '0;
      armed_r   <= 1'b0;
      timeout_r <= srw_pkg::TIMEOUT_RST;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      // output register: one result held until taken
      if (push) begin
        out_v_r <= 1'b1;
        out_r   <= push_res;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (go) begin
        // a new result waits in the pending register so that the last one can be marked
        if (emit) begin
          pend_r   <= gen_res;
          pend_v_r <= 1'b1;
          cnt_r    <= cnt_r + 1'b1;
        end
        unique case (state_r)
          ST_IDLE: begin
            if (cmd_valid) begin
              skip_r <= '0;
              cnt_r  <= '0;
              s_r    <= cmd.seq;
              h_r    <= cmd.handle;
              if (cmd.is_tick) begin
                time_r  <= time_r + 1'b1;
                state_r <= ST_TCHK;
              end else begin
                state_r <= ST_DCLS;
              end
            end
          end
          ST_TCHK: begin
            if (armed_r && !tdiff[TW-1]) begin
              armed_r <= 1'b0;
              aged_r  <= aged_nxt;
              state_r <= ST_TLOOP;
            end else begin
              state_r <= ST_END;
            end
          end
          ST_TLOOP: begin
            if (valid_r[exp_slot]) begin
              valid_r[exp_slot] <= 1'b0;
              exp_r             <= exp_r + 1'b1;
              skip_r            <= '0;
            end else if (|(aged_r & valid_r)) begin
              exp_r  <= exp_r + 1'b1;
              skip_r <= skip_r + 1'b1;
            end else begin
              if (|valid_r) begin
                armed_r <= 1'b1;
                dl_r    <= time_to;
              end
              state_r <= ST_END;
            end
          end
          ST_DCLS: begin
            if (delta[SW-1]) begin
              state_r <= ST_END;
            end else if (|delta[SW-1:SB]) begin
              idx_r   <= '0;
              base_r  <= exp_slot;
              delta_r <= delta;
              state_r <= ST_FLUSH;
            end else begin
              state_r <= ST_STORE;
            end
          end
          ST_FLUSH: begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == SB'(RS - 1)) begin
              valid_r <= '0;
              skip_r  <= delta_r;
              exp_r   <= s_r;
              state_r <= ST_STORE;
            end
          end
          ST_STORE: begin
            if (valid_r[s_slot]) begin
              state_r <= ST_END;
            end else begin
              valid_r[s_slot] <= 1'b1;
              armed_r         <= 1'b1;
              dl_r            <= time_to;
              state_r         <= ST_REL;
            end
          end
          ST_REL: begin
            if (valid_r[exp_slot]) begin
              valid_r[exp_slot] <= 1'b0;
              exp_r             <= exp_r + 1'b1;
              skip_r            <= '0;
            end else begin
              state_r <= ST_END;
            end
          end
          ST_END: begin
            pend_v_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
          default: state_r <= ST_IDLE;
        endcase
      end
      // register writes must arrive only while idle; the block itself does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          srw_pkg::CFG_TIMEOUT:  timeout_r <= cfg_data[srw_pkg::TO_W-1:0];
          srw_pkg::CFG_INIT_SEQ: exp_r     <= cfg_data[SW-1:0];
          default: ;
        endcase
      end
    end
  end

  // slot payload, read only while the slot is valid
  always_ff @(posedge clk) begin
    if (go && state_r == ST_STORE && !valid_r[s_slot]) begin
      handle_r[s_slot] <= h_r;
      arr_r[s_slot]    <= time_r;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sequence_reorder_window.sv @@
// Sequence reorder window, one flow, 16-slot ring. A deliver runs classify,
// store and a release step per released packet; a late packet ends after
// classify, a duplicate after store. A deliver that jumps a full window
// ahead first sweeps the whole ring to flush it. A tick checks the timer
// and ends unless it expires; then it steps through each released packet
// and each skipped number. The back-end sequencer handles one transaction
// at a time; a two-entry queue lets the input keep accepting meanwhile,
// and a result register stalls the sequencer only when a result is not
// taken. Results come one per cycle at best; the last result of a transaction
// has last set. Input transactions that cause no result produce nothing.
`timescale 1ns / 1ps
`default_nettype none
module sequence_reorder_window (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  srw_in_if.sink                                in_ch,
  srw_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [srw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [srw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  srw_pkg::cmd_t f_cmd, q_cmd;
  logic          f_valid, f_ready, q_valid, q_ready;

  srw_front u_front (
    .clk, .rst_n, .in_ch,
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  srw_queue u_queue (
    .clk, .rst_n,
    .wr_cmd(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_cmd(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  srw_back u_back (
    .clk, .rst_n,
    .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .cfg_we, .cfg_index, .cfg_data, .out_ch
  );
endmodule
`default_nettype wire

@@ hw/rtl/srw_checker.sv @@
// Port checker for the reorder window and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "sequence_reorder_window_defines.svh"
module srw_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [srw_pkg::KIND_W-1:0]        out_kind,
  input wire logic [srw_pkg::HANDLE_BITS-1:0]   out_handle,
  input wire logic [srw_pkg::SEQ_W-1:0]         out_seq,
  input wire logic [srw_pkg::SEQ_W-1:0]         out_skipped,
  input wire logic                             out_last
);
  logic [srw_pkg::KIND_W+srw_pkg::HANDLE_BITS+2*srw_pkg::SEQ_W:0] out_word;
  logic is_drop, is_flush;

  assign out_word = {out_kind, out_handle, out_seq, out_skipped, out_last};
  assign is_drop  = out_valid &&
                    (out_kind == srw_pkg::KIND_LATE || out_kind == srw_pkg::KIND_DUP);
  assign is_flush = out_valid && (out_kind == srw_pkg::KIND_FLUSH);

  // stalled result holds
  `SRW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SRW_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_word))
  // a late or duplicate drop is the only result of its transaction
  `SRW_ASSERT_IMP(a_drop_alone, clk, rst_n, is_drop, out_last && out_skipped == '0)
  // a flushed packet never carries a skip count
  `SRW_ASSERT_IMP(a_flush_no_skip, clk, rst_n, is_flush, out_skipped == '0)
endmodule

bind sequence_reorder_window srw_checker u_srw_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
  .out_handle(out_ch.handle_out), .out_seq(out_ch.seq_out),
  .out_skipped(out_ch.skipped_before), .out_last(out_ch.last)
);
`default_nettype wire
